FILE: sv/i2cms_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
package i2cms_pkg;

  // Item kinds on the input channel; code 3 is ignored
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_EVENT = 2'd2
  } action_e;

  // Bus commands issued per item
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_ADDR      = 3'd1,
    CMD_DATA      = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_RECV_ACK  = 3'd4,
    CMD_NACK_STOP = 3'd5,
    CMD_CLEAR     = 3'd6
  } bus_cmd_e;

  // Result flag bits
  localparam logic [7:0] F_OK       = 8'h01;
  localparam logic [7:0] F_FAIL     = 8'h02;
  localparam logic [7:0] F_OVERFLOW = 8'h04;
  localparam logic [7:0] F_ARB      = 8'h08;
  localparam logic [7:0] F_BUSERR   = 8'h10;
  localparam logic [7:0] F_NACK     = 8'h20;
  localparam logic [7:0] F_BUSY     = 8'h40;
  localparam logic [7:0] F_NOACT    = 8'h80;

  // Read bit appended to the shifted address
  localparam logic [7:0] RW_READ = 8'h01;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] slave_address;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [2:0] load_index;
    logic [7:0] load_byte;
    logic       arbitration_lost;
    logic       bus_fault;
    logic       write_irq;
    logic       read_irq;
    logic       nack_seen;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    bus_cmd_e   bus_command;
    logic [7:0] command_value;
    logic       finished;
    logic [7:0] status_flags;
    logic       read_valid;
    logic [7:0] read_value;
    logic [2:0] read_position;
  } out_item_t;

endpackage

FILE: sv/i2cms_in_if.sv
// Input channel: load, start and bus event items.
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] slave_address;
  logic [7:0] write_count;
  logic [7:0] read_count;
  logic [2:0] load_index;
  logic [7:0] load_byte;
  logic       arbitration_lost;
  logic       bus_fault;
  logic       write_irq;
  logic       read_irq;
  logic       nack_seen;
  logic [7:0] received_byte;

  modport source (
    output valid, action, slave_address, write_count, read_count, load_index,
           load_byte, arbitration_lost, bus_fault, write_irq, read_irq,
           nack_seen, received_byte,
    input  ready
  );

  modport sink (
    input  valid, action, slave_address, write_count, read_count, load_index,
           load_byte, arbitration_lost, bus_fault, write_irq, read_irq,
           nack_seen, received_byte,
    output ready
  );
endinterface

FILE: sv/i2cms_out_if.sv
// Output channel: bus command and result items.
interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic [7:0] command_value;
  logic       finished;
  logic [7:0] status_flags;
  logic       read_valid;
  logic [7:0] read_value;
  logic [2:0] read_position;

  modport source (
    output valid, bus_command, command_value, finished, status_flags,
           read_valid, read_value, read_position,
    input  ready
  );

  modport sink (
    input  valid, bus_command, command_value, finished, status_flags,
           read_valid, read_value, read_position,
    output ready
  );
endinterface

FILE: sv/i2cms_sendbuf.sv
// Send byte buffer: one write port, one registered read port with write bypass.
module i2cms_sendbuf #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // new data wins when the same entry is written and read
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/i2cms_core.sv
// Transaction state and per-item command decode.
module i2cms_core import i2cms_pkg::*; #(
  parameter int WRITE_DEPTH = 8,
  parameter int READ_DEPTH  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  localparam int SCW = $clog2(WRITE_DEPTH + 1);
  localparam int RCW = $clog2(READ_DEPTH + 1);
  localparam int AW  = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  logic           open_q,  open_d;
  logic [7:0]     addr_q,  addr_d;
  logic [SCW-1:0] stot_q,  stot_d;
  logic [RCW-1:0] rtot_q,  rtot_d;
  logic [SCW-1:0] sent_q,  sent_d;
  logic [RCW-1:0] rcvd_q,  rcvd_d;
  logic [7:0]     acc_q,   acc_d;

  logic           buf_we;
  logic [AW+2:0]  li_ext;
  logic [AW-1:0]  buf_waddr;
  logic [SCW-1:0] sent_nxt;
  logic [7:0]     buf_rdata;
  logic [RCW+2:0] rcvd_ext;
  logic           wc_over, rc_over, idx_ok;

  assign li_ext    = {{AW{1'b0}}, item_i.load_index};
  assign buf_waddr = li_ext[AW-1:0];
  assign rcvd_ext  = {3'b000, rcvd_q};
  assign wc_over   = item_i.write_count > 8'(WRITE_DEPTH);
  assign rc_over   = item_i.read_count > 8'(READ_DEPTH);
  assign idx_ok    = {5'b00000, item_i.load_index} < 8'(WRITE_DEPTH);

  // read port tracks the count the next item will see
  assign sent_nxt = adv_i ? sent_d : sent_q;

  i2cms_sendbuf #(
    .DEPTH (WRITE_DEPTH),
    .AW    (AW)
  ) u_sendbuf (
    .clk_i   (clk_i),
    .we_i    (buf_we & adv_i),
    .waddr_i (buf_waddr),
    .wdata_i (item_i.load_byte),
    .raddr_i (sent_nxt[AW-1:0]),
    .rdata_o (buf_rdata)
  );

  always_comb begin
    open_d = open_q;
    addr_d = addr_q;
    stot_d = stot_q;
    rtot_d = rtot_q;
    sent_d = sent_q;
    rcvd_d = rcvd_q;
    acc_d  = acc_q;
    buf_we = 1'b0;
    res_o  = '0;

    unique case (item_i.action)
      ACT_LOAD: begin
        buf_we = !open_q && idx_ok;
        res_o.status_flags = acc_q;
      end
      ACT_START: begin
        priority if (wc_over || rc_over) begin
          res_o.finished     = 1'b1;
          res_o.status_flags = F_OVERFLOW;
        end else if (open_q) begin
          res_o.finished     = 1'b1;
          res_o.status_flags = F_BUSY;
        end else if (item_i.write_count == 8'd0 && item_i.read_count == 8'd0) begin
          res_o.finished     = 1'b1;
          res_o.status_flags = F_NOACT;
        end else begin
          open_d = 1'b1;
          addr_d = {item_i.slave_address, 1'b0};
          stot_d = SCW'(item_i.write_count);
          rtot_d = RCW'(item_i.read_count);
          sent_d = '0;
          rcvd_d = '0;
          acc_d  = '0;
          res_o.bus_command   = CMD_ADDR;
          res_o.command_value = (item_i.write_count != 8'd0) ?
                                {item_i.slave_address, 1'b0} :
                                ({item_i.slave_address, 1'b0} | RW_READ);
        end
      end
      ACT_EVENT: begin
        if (open_q) begin
          priority if (item_i.arbitration_lost) begin
            res_o.bus_command = CMD_CLEAR;
            acc_d  = acc_q | F_ARB;
            open_d = 1'b0;
            res_o.finished = 1'b1;
          end else if (item_i.bus_fault) begin
            res_o.bus_command = CMD_CLEAR;
            acc_d  = acc_q | F_BUSERR;
            open_d = 1'b0;
            res_o.finished = 1'b1;
          end else if (item_i.write_irq) begin
            priority if (item_i.nack_seen) begin
              res_o.bus_command = CMD_STOP;
              acc_d  = acc_q | F_NACK;
              open_d = 1'b0;
              res_o.finished = 1'b1;
            end else if (sent_q < stot_q) begin
              res_o.bus_command   = CMD_DATA;
              res_o.command_value = buf_rdata;
              sent_d = sent_q + SCW'(1);
            end else if (rcvd_q < rtot_q) begin
              // repeated start for the read phase
              res_o.bus_command   = CMD_ADDR;
              res_o.command_value = addr_q | RW_READ;
            end else begin
              res_o.bus_command = CMD_STOP;
              acc_d  = acc_q | F_OK;
              open_d = 1'b0;
              res_o.finished = 1'b1;
            end
          end else if (item_i.read_irq) begin
            if (rcvd_q < RCW'(READ_DEPTH)) begin
              res_o.read_valid    = 1'b1;
              res_o.read_value    = item_i.received_byte;
              res_o.read_position = rcvd_ext[2:0];
              rcvd_d = rcvd_q + RCW'(1);
            end else begin
              acc_d = acc_q | F_OVERFLOW;
            end
            if (rcvd_d < rtot_q) begin
              res_o.bus_command = CMD_RECV_ACK;
            end else begin
              res_o.bus_command = CMD_NACK_STOP;
              acc_d  = acc_d | F_OK;
              open_d = 1'b0;
              res_o.finished = 1'b1;
            end
          end else begin
            acc_d  = acc_q | F_FAIL;
            open_d = 1'b0;
            res_o.finished = 1'b1;
          end
          res_o.status_flags = acc_d;
        end
      end
      default: begin
        res_o.status_flags = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      addr_q <= '0;
      stot_q <= '0;
      rtot_q <= '0;
      sent_q <= '0;
      rcvd_q <= '0;
      acc_q  <= '0;
    end else if (adv_i) begin
      open_q <= open_d;
      addr_q <= addr_d;
      stot_q <= stot_d;
      rtot_q <= rtot_d;
      sent_q <= sent_d;
      rcvd_q <= rcvd_d;
      acc_q  <= acc_d;
    end
  end

endmodule

FILE: sv/i2c_master_transaction_sequencer.sv
// Top level of the I2C master write-then-read transaction sequencer.
//
//   channel  dir  handshake       carries
//   in_i     in   valid/ready     load byte, start request or bus event
//   out_o    out  valid/ready     bus command, flags, received byte
//
// One item per clock sustained while out_o is ready. An accepted item goes
// into the input register, is decoded against the transaction state in a
// single pass and lands in the result register, which drives out_o.valid.
// The send buffer read port is registered; it is aimed at the next item's
// send position so the data byte is ready when the write event arrives.
// A stalled result holds; the input register keeps filling until it too is
// full, then in_i.ready drops. Reset closes any transaction, clears flags.
module i2c_master_transaction_sequencer import i2cms_pkg::*; #(
  parameter int WRITE_DEPTH = 8,
  parameter int READ_DEPTH  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cms_in_if.sink      in_i,
  i2cms_out_if.source   out_o
);

  in_item_t  s1_q;
  logic      s1_valid_q, s1_valid_d;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      in_acc, adv;

  // decode stage moves whenever the result register is free or draining
  assign adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_acc = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || adv;

  assign s1_valid_d  = in_acc || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !out_o.ready);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.action           <= in_i.action;
      s1_q.slave_address    <= in_i.slave_address;
      s1_q.write_count      <= in_i.write_count;
      s1_q.read_count       <= in_i.read_count;
      s1_q.load_index       <= in_i.load_index;
      s1_q.load_byte        <= in_i.load_byte;
      s1_q.arbitration_lost <= in_i.arbitration_lost;
      s1_q.bus_fault        <= in_i.bus_fault;
      s1_q.write_irq        <= in_i.write_irq;
      s1_q.read_irq         <= in_i.read_irq;
      s1_q.nack_seen        <= in_i.nack_seen;
      s1_q.received_byte    <= in_i.received_byte;
    end
  end

  // state and command decode
  i2cms_core #(
    .WRITE_DEPTH (WRITE_DEPTH),
    .READ_DEPTH  (READ_DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (s1_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.bus_command   = out_q.bus_command;
  assign out_o.command_value = out_q.command_value;
  assign out_o.finished      = out_q.finished;
  assign out_o.status_flags  = out_q.status_flags;
  assign out_o.read_valid    = out_q.read_valid;
  assign out_o.read_value    = out_q.read_value;
  assign out_o.read_position = out_q.read_position;

`ifndef SYNTH
  // a received byte only comes with a receive command
  a_read_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.read_valid |->
      out_q.bus_command == CMD_RECV_ACK || out_q.bus_command == CMD_NACK_STOP)
    else $error("received byte without receive command");

  // clear error always ends the transaction
  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bus_command == CMD_CLEAR |-> out_q.finished)
    else $error("clear error without finish");

  // command value is only used by address and data commands
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.command_value != 8'd0 |->
      out_q.bus_command == CMD_ADDR || out_q.bus_command == CMD_DATA)
    else $error("stray command value");

  // a stalled result is not overwritten by the decode stage
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !adv)
    else $error("result register overrun");
`endif

endmodule

FILE: tb/i2c_master_transaction_sequencer_tb.sv
// Self-checking testbench for the I2C master transaction sequencer.
module i2c_master_transaction_sequencer_tb;
  import i2cms_pkg::*;

  localparam int         WR_DEPTH     = 8;
  localparam int         RD_DEPTH     = 8;
  localparam int         ITEM_TARGET  = 1550;
  localparam int         MAX_REPORTS  = 10;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         LIMIT_CYCLES = 400_000;
  // action code 3 has no enum member; the block ignores it
  localparam logic [1:0] ACT_IGNORED  = 2'd3;

  // ways a transaction is cut short
  typedef enum int {END_ARB, END_BUS_FAULT, END_NACK, END_NO_FLAG} abort_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  i2cms_in_if  in_if ();
  i2cms_out_if out_if ();

  i2c_master_transaction_sequencer #(
    .WRITE_DEPTH(WR_DEPTH),
    .READ_DEPTH (RD_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Transaction state as the sequencer should hold it
  logic       txn_open   = 1'b0;
  logic [7:0] addr_byte  = '0;
  logic [7:0] send_buf [WR_DEPTH];
  logic [3:0] send_total = '0;
  logic [3:0] recv_total = '0;
  logic [3:0] sent_cnt   = '0;
  logic [3:0] recv_cnt   = '0;
  logic [7:0] flag_acc   = '0;

  out_item_t   pending_results [$];
  int unsigned items_issued   = 0;
  int unsigned mismatch_count = 0;

  bit idle_on  = 1'b1;  // random gaps on both sides
  int rx_hold  = 0;     // long output stall, counted down by the ready driver
  int rx_stall = 0;     // per-item output stall

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void close_txn(inout out_item_t r, input logic [7:0] flags);
    flag_acc   = flag_acc | flags;
    txn_open   = 1'b0;
    r.finished = 1'b1;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.action)
      ACT_LOAD: begin
        // loads are dropped while a transaction owns the buffer
        if (!txn_open) send_buf[it.load_index] = it.load_byte;
        r.status_flags = flag_acc;
      end
      ACT_START: begin
        if (it.write_count > WR_DEPTH || it.read_count > RD_DEPTH) begin
          r.finished     = 1'b1;
          r.status_flags = F_OVERFLOW;
        end else if (txn_open) begin
          r.finished     = 1'b1;
          r.status_flags = F_BUSY;
        end else if (it.write_count == 0 && it.read_count == 0) begin
          r.finished     = 1'b1;
          r.status_flags = F_NOACT;
        end else begin
          txn_open        = 1'b1;
          addr_byte       = {it.slave_address, 1'b0};
          send_total      = it.write_count[3:0];
          recv_total      = it.read_count[3:0];
          sent_cnt        = '0;
          recv_cnt        = '0;
          flag_acc        = '0;
          r.bus_command   = CMD_ADDR;
          // read-only transaction addresses the slave for reading at once
          r.command_value = (it.write_count != 0) ? addr_byte : (addr_byte | RW_READ);
        end
      end
      ACT_EVENT: begin
        if (txn_open) begin
          if (it.arbitration_lost) begin
            r.bus_command = CMD_CLEAR;
            close_txn(r, F_ARB);
          end else if (it.bus_fault) begin
            r.bus_command = CMD_CLEAR;
            close_txn(r, F_BUSERR);
          end else if (it.write_irq) begin
            if (it.nack_seen) begin
              r.bus_command = CMD_STOP;
              close_txn(r, F_NACK);
            end else if (sent_cnt < send_total) begin
              r.bus_command   = CMD_DATA;
              r.command_value = send_buf[sent_cnt[2:0]];
              sent_cnt++;
            end else if (recv_cnt < recv_total) begin
              // repeated start for the read phase
              r.bus_command   = CMD_ADDR;
              r.command_value = addr_byte | RW_READ;
            end else begin
              r.bus_command = CMD_STOP;
              close_txn(r, F_OK);
            end
          end else if (it.read_irq) begin
            if (recv_cnt < RD_DEPTH) begin
              r.read_valid    = 1'b1;
              r.read_value    = it.received_byte;
              r.read_position = recv_cnt[2:0];
              recv_cnt++;
            end else begin
              flag_acc = flag_acc | F_OVERFLOW;
            end
            if (recv_cnt < recv_total) begin
              r.bus_command = CMD_RECV_ACK;
            end else begin
              r.bus_command = CMD_NACK_STOP;
              close_txn(r, F_OK);
            end
          end else begin
            // event with no status bit: give up on the transaction
            close_txn(r, F_FAIL);
          end
          r.status_flags = flag_acc;
        end
      end
      default: r.status_flags = flag_acc;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // every field random, so unused fields still toggle
  function automatic in_item_t rand_item();
    in_item_t it;
    it.action           = 2'($urandom_range(0, 3));
    it.slave_address    = 7'($urandom_range(0, 127));
    it.write_count      = 8'($urandom_range(0, 255));
    it.read_count       = 8'($urandom_range(0, 255));
    it.load_index       = 3'($urandom_range(0, 7));
    it.load_byte        = 8'($urandom_range(0, 255));
    it.arbitration_lost = coin();
    it.bus_fault        = coin();
    it.write_irq        = coin();
    it.read_irq         = coin();
    it.nack_seen        = coin();
    it.received_byte    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t load_item(logic [2:0] idx, logic [7:0] data);
    in_item_t it;
    it            = rand_item();
    it.action     = ACT_LOAD;
    it.load_index = idx;
    it.load_byte  = data;
    return it;
  endfunction

  function automatic in_item_t start_item(logic [6:0] addr, logic [7:0] wc, logic [7:0] rc);
    in_item_t it;
    it               = rand_item();
    it.action        = ACT_START;
    it.slave_address = addr;
    it.write_count   = wc;
    it.read_count    = rc;
    return it;
  endfunction

  function automatic in_item_t event_item(logic arb, logic fault, logic wirq, logic rirq,
                                          logic nack);
    in_item_t it;
    it                  = rand_item();
    it.action           = ACT_EVENT;
    it.arbitration_lost = arb;
    it.bus_fault        = fault;
    it.write_irq        = wirq;
    it.read_irq         = rirq;
    it.nack_seen        = nack;
    return it;
  endfunction

  // lower-priority status bits are random, they must lose
  function automatic in_item_t abort_item(abort_e kind);
    logic [3:0] r;
    r = 4'($urandom_range(0, 15));
    case (kind)
      END_ARB:       return event_item(1'b1, r[0], r[1], r[2], r[3]);
      END_BUS_FAULT: return event_item(1'b0, 1'b1, r[1], r[2], r[3]);
      END_NACK:      return event_item(1'b0, 1'b0, 1'b1, r[2], 1'b1);
      default:       return event_item(1'b0, 1'b0, 1'b0, 1'b0, r[3]);
    endcase
  endfunction

  // load, start or ignored code: harmless or refused while a transaction is open
  function automatic in_item_t stray_item();
    in_item_t it;
    it = rand_item();
    case ($urandom_range(0, 2))
      0: it.action = ACT_LOAD;
      1: begin
        it.action = ACT_START;
        if (coin()) begin
          it.write_count = 8'($urandom_range(0, WR_DEPTH + 1));
          it.read_count  = 8'($urandom_range(0, RD_DEPTH + 1));
        end
      end
      default: it.action = ACT_IGNORED;
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.action           = it.action;
    in_if.slave_address    = it.slave_address;
    in_if.write_count      = it.write_count;
    in_if.read_count       = it.read_count;
    in_if.load_index       = it.load_index;
    in_if.load_byte        = it.load_byte;
    in_if.arbitration_lost = it.arbitration_lost;
    in_if.bus_fault        = it.bus_fault;
    in_if.write_irq        = it.write_irq;
    in_if.read_irq         = it.read_irq;
    in_if.nack_seen        = it.nack_seen;
    in_if.received_byte    = it.received_byte;
    in_if.valid            = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pending_results.push_back(predict_result(it));
    items_issued++;
  endtask

  // drop valid, then wait for every outstanding result
  task automatic wait_results_done();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // One well-formed transaction with random content; sometimes cut short,
  // sometimes with stray items mixed into the bus phase.
  task automatic run_transaction();
    int wc;
    int rc;
    int n_write;
    int steps;
    int abort_at;
    int i;
    repeat ($urandom_range(0, 4))
      send_item(load_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
    wc = $urandom_range(0, WR_DEPTH);
    rc = $urandom_range(0, RD_DEPTH);
    if ($urandom_range(0, 15) == 0) begin
      if (coin()) wc = $urandom_range(WR_DEPTH + 1, 255);
      else rc = $urandom_range(RD_DEPTH + 1, 255);
    end
    send_item(start_item(7'($urandom_range(0, 127)), 8'(wc), 8'(rc)));
    if (wc > WR_DEPTH || rc > RD_DEPTH || (wc == 0 && rc == 0)) return;

    // write events: data bytes, then repeated start or stop
    n_write  = (wc > 0) ? wc + 1 : 0;
    steps    = n_write + rc;
    abort_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, steps - 1) : -1;
    for (i = 0; i < steps; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(stray_item());
      if (i == abort_at) begin
        send_item(abort_item(abort_e'($urandom_range(0, 3))));
        return;
      end
      if (i < n_write) send_item(event_item(1'b0, 1'b0, 1'b1, coin(), 1'b0));
      else send_item(event_item(1'b0, 1'b0, 1'b0, 1'b1, coin()));
    end
    // late event after the stop: nothing open, ignored
    if ($urandom_range(0, 5) == 0)
      send_item(event_item(coin(), coin(), coin(), coin(), coin()));
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_if.ready = 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_if.ready = 1'b0;
      rx_stall--;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  function automatic void report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endfunction

  task automatic check_result();
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none pending, bus_command", '0, 8'(out_if.bus_command));
      return;
    end
    want = pending_results.pop_front();
    check_field("bus_command",   8'(want.bus_command),   8'(out_if.bus_command));
    check_field("command_value", want.command_value,     out_if.command_value);
    check_field("finished",      8'(want.finished),      8'(out_if.finished));
    check_field("status_flags",  want.status_flags,      out_if.status_flags);
    check_field("read_valid",    8'(want.read_valid),    8'(out_if.read_valid));
    check_field("read_value",    want.read_value,        out_if.read_value);
    check_field("read_position", 8'(want.read_position), 8'(out_if.read_position));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      check_result();
      rx_stall = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every buffer entry gets a value before any transaction can send it.
  task automatic test_buffer_fill();
    logic [7:0] pattern [WR_DEPTH];
    int i;
    pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
    for (i = 0; i < WR_DEPTH; i++) send_item(load_item(3'(i), pattern[i]));
  endtask

  task automatic test_start_refusals();
    in_item_t it;
    send_item(start_item(7'h55, 8'(WR_DEPTH + 1), 8'd0));  // write count one too many
    send_item(start_item(7'h2A, 8'(WR_DEPTH), 8'hFF));     // read count far too large
    send_item(start_item(7'h00, 8'd0, 8'd0));              // nothing to do
    it        = rand_item();
    it.action = ACT_IGNORED;
    send_item(it);
  endtask

  task automatic test_write_then_read();
    send_item(start_item(7'h7F, 8'd1, 8'd1));
    send_item(start_item(7'h03, 8'd1, 8'd1));        // busy
    send_item(load_item(3'd0, 8'h33));               // dropped, buffer owned
    send_item(event_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(event_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(event_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic test_abort_paths();
    in_item_t it;
    send_item(start_item(7'h00, 8'(WR_DEPTH), 8'(RD_DEPTH)));
    send_item(event_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));  // arbitration wins
    send_item(start_item(7'h01, 8'd0, 8'd1));
    send_item(event_item(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));  // bus fault wins
    send_item(start_item(7'h02, 8'd2, 8'd0));
    send_item(event_item(1'b0, 1'b0, 1'b1, 1'b1, 1'b1));  // write NACKed
    send_item(start_item(7'h04, 8'd0, 8'(RD_DEPTH)));
    it               = event_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    it.received_byte = 8'h00;
    send_item(it);
    send_item(event_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));  // no status bit
    send_item(event_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));  // nothing open
  endtask

  // Output stalls long enough for the block to back up into its input.
  task automatic test_output_hold_off();
    idle_on = 1'b0;
    rx_hold = HOLD_CYCLES;
    repeat (10) send_item(load_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
    repeat (4) run_transaction();
    wait_results_done();
    idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (3) run_transaction();
    wait_results_done();
    repeat (3) run_transaction();
  endtask

  task automatic test_random_traffic();
    while (items_issued < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 39))
        0: wait_results_done();
        1, 2, 3, 4: begin
          repeat ($urandom_range(1, 4)) send_item(coin() ? rand_item() : stray_item());
          // close anything a stray start may have opened
          send_item(event_item(1'b0, 1'b0, 1'b0, 1'b0, coin()));
        end
        default: run_transaction();
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid            = 1'b0;
    in_if.action           = ACT_LOAD;
    in_if.slave_address    = '0;
    in_if.write_count      = '0;
    in_if.read_count       = '0;
    in_if.load_index       = '0;
    in_if.load_byte        = '0;
    in_if.arbitration_lost = 1'b0;
    in_if.bus_fault        = 1'b0;
    in_if.write_irq        = 1'b0;
    in_if.read_irq         = 1'b0;
    in_if.nack_seen        = 1'b0;
    in_if.received_byte    = '0;
    out_if.ready           = 1'b0;
    foreach (send_buf[i]) send_buf[i] = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_buffer_fill();
    test_start_refusals();
    test_write_then_read();
    test_abort_paths();
    test_output_hold_off();
    test_sender_pause();
    test_random_traffic();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("TB_ERROR");
    $finish;
  end

endmodule
